/* hw/rtl/rqer_pkg.sv */
`timescale 1ns / 1ps

package rqer_pkg;

   localparam int MAX_DIM = 4096;
   localparam int COORD_W = $clog2(MAX_DIM);
   localparam int DIM_W   = $clog2(MAX_DIM) + 1;
   localparam int CORNER_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = CORNER_W;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_A_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_A_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_B_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_B_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EXCHANGE_MODE = 3'd6;

   // Exchange modes
   localparam logic [1:0] MODE_CW   = 2'd0;
   localparam logic [1:0] MODE_CCW  = 2'd1;
   localparam logic [1:0] MODE_DIAG = 2'd2;

   // Quadrant codes: bit 0 is the right half, bit 1 the lower half
   localparam logic [1:0] QUAD_UL = 2'd0;
   localparam logic [1:0] QUAD_UR = 2'd1;
   localparam logic [1:0] QUAD_LL = 2'd2;
   localparam logic [1:0] QUAD_LR = 2'd3;

   // Rectangle geometry in stored coordinates, derived from the registers
   typedef struct packed {
      logic [1:0]         mode;
      logic [COORD_W-1:0] x0;      // left edge
      logic [COORD_W-1:0] mx;      // first column of the right half
      logic [COORD_W-1:0] mx_end;  // one past the right half
      logic [COORD_W-1:0] y0;      // top stored row
      logic [COORD_W-1:0] my;      // first row of the lower half
      logic [COORD_W-1:0] my_end;  // one below the lower half
   } geom_type;

   // Last valid index of a dimension, dimension taken within 1..MAX_DIM
   function automatic logic [COORD_W-1:0] dim_last(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] t;
      t = d - DIM_W'(1);
      if (d == '0) begin
         return '0;
      end else if (d > DIM_W'(MAX_DIM)) begin
         return COORD_W'(MAX_DIM - 1);
      end
      return t[COORD_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] clamp_col(input logic signed [CORNER_W-1:0] v,
                                                    input logic [COORD_W-1:0] last);
      if (v[CORNER_W-1]) begin
         return '0;
      end else if ({1'b0, v[CORNER_W-2:0]} > CORNER_W'(last)) begin
         return last;
      end
      return v[COORD_W-1:0];
   endfunction

   // Flip a user row to a stored row (last - v) and clamp to the image
   function automatic logic [COORD_W-1:0] flip_row(input logic signed [CORNER_W-1:0] v,
                                                   input logic [COORD_W-1:0] last);
      logic signed [CORNER_W+1:0] t;
      t = $signed({{(CORNER_W+2-COORD_W){1'b0}}, last})
          - $signed({{2{v[CORNER_W-1]}}, v});
      if (t[CORNER_W+1]) begin
         return '0;
      end else if (t > $signed({{(CORNER_W+2-COORD_W){1'b0}}, last})) begin
         return last;
      end
      return t[COORD_W-1:0];
   endfunction

   // Quadrant that a destination quadrant takes its pixels from
   function automatic logic [1:0] src_quad(input logic [1:0] mode, input logic [1:0] q);
      logic [1:0] s;
      s = q;
      case (mode)
         MODE_CW: begin
            case (q)
               QUAD_UL: s = QUAD_LL;
               QUAD_UR: s = QUAD_UL;
               QUAD_LL: s = QUAD_LR;
               default: s = QUAD_UR;
            endcase
         end
         MODE_CCW: begin
            case (q)
               QUAD_UL: s = QUAD_UR;
               QUAD_UR: s = QUAD_LR;
               QUAD_LL: s = QUAD_UL;
               default: s = QUAD_LL;
            endcase
         end
         MODE_DIAG: begin
            case (q)
               QUAD_UL: s = QUAD_LR;
               QUAD_UR: s = QUAD_LL;
               QUAD_LL: s = QUAD_UR;
               default: s = QUAD_UL;
            endcase
         end
         default: s = q;  // unused mode: no exchange
      endcase
      return s;
   endfunction

endpackage

/* hw/rtl/rqer_geom.sv */
`timescale 1ns / 1ps

module rqer_geom (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [rqer_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rqer_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output rqer_pkg::geom_type                  geom
);

   logic signed [rqer_pkg::CORNER_W-1:0] corner_a_x_ff;
   logic signed [rqer_pkg::CORNER_W-1:0] corner_a_y_ff;
   logic signed [rqer_pkg::CORNER_W-1:0] corner_b_x_ff;
   logic signed [rqer_pkg::CORNER_W-1:0] corner_b_y_ff;
   logic [rqer_pkg::DIM_W-1:0]           image_width_ff;
   logic [rqer_pkg::DIM_W-1:0]           image_height_ff;
   logic [1:0]                           exchange_mode_ff;

   rqer_pkg::geom_type geom_ff;
   rqer_pkg::geom_type geom_in;

   logic [rqer_pkg::COORD_W-1:0] w_last;
   logic [rqer_pkg::COORD_W-1:0] h_last;
   logic [rqer_pkg::COORD_W-1:0] xa, xb, ya, yb;
   logic [rqer_pkg::COORD_W-1:0] x_lo, x_hi, y_top, y_bot;
   logic [rqer_pkg::COORD_W-1:0] hx, hy;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_a_x_ff    <= '0;
         corner_a_y_ff    <= '0;
         corner_b_x_ff    <= '0;
         corner_b_y_ff    <= '0;
         image_width_ff   <= rqer_pkg::DIM_W'(1);
         image_height_ff  <= rqer_pkg::DIM_W'(1);
         exchange_mode_ff <= rqer_pkg::MODE_CW;
      end else if (csr_write_en) begin
         unique case (csr_index)
            rqer_pkg::CSR_CORNER_A_X:    corner_a_x_ff <= csr_wdata;
            rqer_pkg::CSR_CORNER_A_Y:    corner_a_y_ff <= csr_wdata;
            rqer_pkg::CSR_CORNER_B_X:    corner_b_x_ff <= csr_wdata;
            rqer_pkg::CSR_CORNER_B_Y:    corner_b_y_ff <= csr_wdata;
            rqer_pkg::CSR_IMAGE_WIDTH:   image_width_ff <= csr_wdata[rqer_pkg::DIM_W-1:0];
            rqer_pkg::CSR_IMAGE_HEIGHT:  image_height_ff <= csr_wdata[rqer_pkg::DIM_W-1:0];
            rqer_pkg::CSR_EXCHANGE_MODE: exchange_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_last = rqer_pkg::dim_last(image_width_ff);
      h_last = rqer_pkg::dim_last(image_height_ff);
      xa = rqer_pkg::clamp_col(corner_a_x_ff, w_last);
      xb = rqer_pkg::clamp_col(corner_b_x_ff, w_last);
      ya = rqer_pkg::flip_row(corner_a_y_ff, h_last);
      yb = rqer_pkg::flip_row(corner_b_y_ff, h_last);
      x_lo  = (xa > xb) ? xb : xa;
      x_hi  = (xa > xb) ? xa : xb;
      y_top = (ya < yb) ? yb : ya;
      y_bot = (ya < yb) ? ya : yb;
      hx = (x_hi - x_lo) >> 1;
      hy = (y_top - y_bot) >> 1;
      geom_in.mode   = exchange_mode_ff;
      geom_in.x0     = x_lo;
      geom_in.mx     = x_lo + hx;
      geom_in.mx_end = x_lo + hx + hx;
      geom_in.y0     = y_top;
      geom_in.my     = y_top - hy;
      geom_in.my_end = y_top - hy - hy;
   end

   // Reset value matches the geometry of the reset register values
   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff <= '0;
      end else begin
         geom_ff <= geom_in;
      end
   end

   assign geom = geom_ff;

endmodule

/* hw/rtl/rqer_map.sv */
`timescale 1ns / 1ps

module rqer_map (
   input  logic                               clock,
   input  logic                               reset,
   input  rqer_pkg::geom_type                 geom,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rqer_pkg::COORD_W-1:0]       req_pixel_col,
   input  logic [rqer_pkg::COORD_W-1:0]       req_pixel_row,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rqer_pkg::COORD_W-1:0]       rsp_source_col,
   output logic [rqer_pkg::COORD_W-1:0]       rsp_source_row,
   output logic                               rsp_in_quadrant,
   output logic [1:0]                         rsp_quadrant_id,
   output logic                               hold_valid
);

   logic                         s1_valid_ff;
   logic [rqer_pkg::COORD_W-1:0] s1_col_ff;
   logic [rqer_pkg::COORD_W-1:0] s1_row_ff;

   logic                         rsp_valid_ff;
   logic [rqer_pkg::COORD_W-1:0] rsp_col_ff, rsp_col_in;
   logic [rqer_pkg::COORD_W-1:0] rsp_row_ff, rsp_row_in;
   logic                         rsp_inq_ff, rsp_inq_in;
   logic [1:0]                   rsp_qid_ff, rsp_qid_in;

   logic out_free;
   logic s1_move;
   logic s1_ready;
   logic req_take;

   logic col_lo, col_hi, row_lo, row_hi, in_quad;
   logic [1:0] q, s;
   logic [rqer_pkg::COORD_W-1:0] col_cur, col_src, row_cur, row_src;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_move  = s1_valid_ff && out_free;
   assign s1_ready = !s1_valid_ff || out_free;
   assign req_take = req_valid && s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_col_ff <= req_pixel_col;
         s1_row_ff <= req_pixel_row;
      end
   end

   always_comb begin
      col_lo = (s1_col_ff >= geom.x0) && (s1_col_ff < geom.mx);
      col_hi = !col_lo && (s1_col_ff >= geom.mx) && (s1_col_ff < geom.mx_end);
      row_lo = (s1_row_ff <= geom.y0) && (s1_row_ff > geom.my);
      row_hi = !row_lo && (s1_row_ff <= geom.my) && (s1_row_ff > geom.my_end);
      in_quad = (col_lo || col_hi) && (row_lo || row_hi);
      q = {row_hi, col_hi};
      s = rqer_pkg::src_quad(geom.mode, q);
      // keep the offset inside the quadrant: src = pixel - own base + source base
      col_cur = col_hi ? geom.mx : geom.x0;
      col_src = s[0] ? geom.mx : geom.x0;
      row_cur = row_hi ? geom.my : geom.y0;
      row_src = s[1] ? geom.my : geom.y0;
      if (in_quad) begin
         rsp_col_in = s1_col_ff - col_cur + col_src;
         rsp_row_in = s1_row_ff - row_cur + row_src;
         rsp_qid_in = q;
      end else begin
         rsp_col_in = s1_col_ff;
         rsp_row_in = s1_row_ff;
         rsp_qid_in = rqer_pkg::QUAD_UL;
      end
      rsp_inq_in = in_quad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_col_ff <= rsp_col_in;
         rsp_row_ff <= rsp_row_in;
         rsp_inq_ff <= rsp_inq_in;
         rsp_qid_ff <= rsp_qid_in;
      end
   end

   assign req_stall       = !s1_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_source_col  = rsp_col_ff;
   assign rsp_source_row  = rsp_row_ff;
   assign rsp_in_quadrant = rsp_inq_ff;
   assign rsp_quadrant_id = rsp_qid_ff;
   assign hold_valid      = s1_valid_ff;

endmodule

/* hw/rtl/region_quadrant_exchange_remap.sv */
`timescale 1ns / 1ps
// A request passes the input register, then the output register, to its response.
// Throughput: one transaction per cycle while rsp_stall is low; the response register
// frees the request side. Geometry derived from a register write is itself registered.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults:
// corners 0, width 1, height 1, clockwise mode.

module region_quadrant_exchange_remap (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [rqer_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rqer_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rqer_pkg::COORD_W-1:0]       req_pixel_col,
   input  logic [rqer_pkg::COORD_W-1:0]       req_pixel_row,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rqer_pkg::COORD_W-1:0]       rsp_source_col,
   output logic [rqer_pkg::COORD_W-1:0]       rsp_source_row,
   output logic                               rsp_in_quadrant,
   output logic [1:0]                         rsp_quadrant_id
);

   rqer_pkg::geom_type geom;
   logic               hold_valid;

   rqer_geom u_geom (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .geom         (geom)
   );

   rqer_map u_map (
      .clock           (clock),
      .reset           (reset),
      .geom            (geom),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_col   (req_pixel_col),
      .req_pixel_row   (req_pixel_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_source_col  (rsp_source_col),
      .rsp_source_row  (rsp_source_row),
      .rsp_in_quadrant (rsp_in_quadrant),
      .rsp_quadrant_id (rsp_quadrant_id),
      .hold_valid      (hold_valid)
   );

`ifndef ASSERT_OFF
   // a full input register behind a blocked response must hold off new requests
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (hold_valid && rsp_valid && rsp_stall) |-> req_stall)
      else $error("request accepted while pipeline is full");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> hold_valid)
      else $error("accepted transaction lost from the input register");

   a_outside_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_quadrant) |-> (rsp_quadrant_id == rqer_pkg::QUAD_UL))
      else $error("quadrant id set for a pixel outside the quadrants");
`endif

endmodule

/* dv/region_quadrant_exchange_remap_tb.sv */
`timescale 1ns / 1ps

module region_quadrant_exchange_remap_tb;
   import rqer_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int NUM_REGS     = 7;
   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_ITEMS  = 250;
   localparam int COORD_MAX    = (1 << COORD_W) - 1;
   localparam int DIM_REG_MAX  = (1 << DIM_W) - 1;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               in_quad;
      logic [1:0]         quad;
   } remap_type;

   class remap_scoreboard;
      logic signed [CORNER_W-1:0] a_x, a_y, b_x, b_y;
      logic [DIM_W-1:0]           width, height;
      logic [1:0]                 mode;
      logic [1:0]                 src_of [4][4];
      remap_type                  expected_q [$];
      int                         errors;
      int                         checked;

      function new();
         a_x = '0;
         a_y = '0;
         b_x = '0;
         b_y = '0;
         width = DIM_W'(1);
         height = DIM_W'(1);
         mode = MODE_CW;
         // source quadrant per destination quadrant UL, UR, LL, LR
         src_of[MODE_CW]     = '{QUAD_LL, QUAD_UL, QUAD_LR, QUAD_UR};
         src_of[MODE_CCW]    = '{QUAD_UR, QUAD_LR, QUAD_UL, QUAD_LL};
         src_of[MODE_DIAG]   = '{QUAD_LR, QUAD_LL, QUAD_UR, QUAD_UL};
         src_of[MODE_UNUSED] = '{QUAD_UL, QUAD_UR, QUAD_LL, QUAD_LR};
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CORNER_A_X:    a_x = data;
            CSR_CORNER_A_Y:    a_y = data;
            CSR_CORNER_B_X:    b_x = data;
            CSR_CORNER_B_Y:    b_y = data;
            CSR_IMAGE_WIDTH:   width = data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:  height = data[DIM_W-1:0];
            CSR_EXCHANGE_MODE: mode = data[1:0];
            default: ;
         endcase
      endfunction

      static function int bound(int v, int lo, int hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function remap_type predict(logic [COORD_W-1:0] px_in, logic [COORD_W-1:0] py_in);
         remap_type  r;
         int         w, h, px, py, x0, x1, y0, y1, t, hx, hy, mx, my, i, j, sc, sr;
         logic       in_c, in_r, cq, rq;
         logic [1:0] q, s;
         w = bound(int'(width), 1, MAX_DIM);
         h = bound(int'(height), 1, MAX_DIM);
         px = int'(px_in);
         py = int'(py_in);
         x0 = bound(int'(a_x), 0, w - 1);
         x1 = bound(int'(b_x), 0, w - 1);
         // flip user rows to stored rows
         y0 = bound(h - int'(a_y) - 1, 0, h - 1);
         y1 = bound(h - int'(b_y) - 1, 0, h - 1);
         if (x0 > x1) begin
            t = x0;
            x0 = x1;
            x1 = t;
         end
         if (y0 < y1) begin
            t = y0;
            y0 = y1;
            y1 = t;
         end
         hx = (x1 - x0) / 2;
         hy = (y0 - y1) / 2;
         mx = x0 + hx;
         my = y0 - hy;
         in_c = 1'b1;
         in_r = 1'b1;
         cq = 1'b0;
         rq = 1'b0;
         i = 0;
         j = 0;
         if (px >= x0 && px < mx) begin
            i = px - x0;
         end else if (px >= mx && px < mx + hx) begin
            cq = 1'b1;
            i = px - mx;
         end else begin
            in_c = 1'b0;
         end
         if (py <= y0 && py > my) begin
            j = y0 - py;
         end else if (py <= my && py > my - hy) begin
            rq = 1'b1;
            j = my - py;
         end else begin
            in_r = 1'b0;
         end
         sc = px;
         sr = py;
         q = QUAD_UL;
         if (in_c && in_r) begin
            q = {rq, cq};
            s = src_of[mode][q];
            sc = s[0] ? mx + i : x0 + i;
            sr = s[1] ? my - j : y0 - j;
         end
         r.col = COORD_W'(sc);
         r.row = COORD_W'(sr);
         r.in_quad = in_c && in_r;
         r.quad = q;
         return r;
      endfunction

      function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
         expected_q.push_back(predict(col, row));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void check_result(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                                 logic in_quad, logic [1:0] quad);
         remap_type e;
         checked++;
         if (expected_q.size() == 0) begin
            errors++;
            $error("response with nothing outstanding: source_col %0d source_row %0d",
                   col, row);
            return;
         end
         e = expected_q.pop_front();
         if (col !== e.col) begin
            errors++;
            $error("source_col: expected %0d, actual %0d", e.col, col);
         end
         if (row !== e.row) begin
            errors++;
            $error("source_row: expected %0d, actual %0d", e.row, row);
         end
         if (in_quad !== e.in_quad) begin
            errors++;
            $error("in_quadrant: expected %0d, actual %0d", e.in_quad, in_quad);
         end
         if (quad !== e.quad) begin
            errors++;
            $error("quadrant_id: expected %0d, actual %0d", e.quad, quad);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [COORD_W-1:0]    req_pixel_col = '0;
   logic [COORD_W-1:0]    req_pixel_row = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COORD_W-1:0]    rsp_source_col;
   logic [COORD_W-1:0]    rsp_source_row;
   logic                  rsp_in_quadrant;
   logic [1:0]            rsp_quadrant_id;

   remap_scoreboard sb;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int hold_requests = 0;
   int settings_done = 0;
   int pix_w = 1;
   int pix_h = 1;
   int quiet_cycles = 0;

   region_quadrant_exchange_remap u_top (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin
      int hold_served;
      int hold_left;
      hold_served = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_source_col, rsp_source_row, rsp_in_quadrant, rsp_quadrant_id);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int eff_extent(int d);
      return (d < 1) ? 1 : ((d > MAX_DIM) ? MAX_DIM : d);
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(9))
         0:       return 0;
         1:       return 1;
         2:       return $urandom_range(MAX_DIM + 1, DIM_REG_MAX);
         3:       return MAX_DIM;
         4:       return $urandom_range(1, MAX_DIM);
         default: return $urandom_range(2, 40);
      endcase
   endfunction

   // mostly near the image, now and then any 16-bit value
   function automatic logic [CSR_DATA_W-1:0] pick_corner(int extent);
      int v;
      if ($urandom_range(4) == 0) begin
         return CSR_DATA_W'($urandom());
      end
      v = int'($urandom_range(0, extent + 3)) - 2;
      return CSR_DATA_W'(v);
   endfunction

   task automatic drive_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_col <= col;
      req_pixel_row <= row;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(col, row);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] ax, input logic [CSR_DATA_W-1:0] ay,
                               input logic [CSR_DATA_W-1:0] bx, input logic [CSR_DATA_W-1:0] by,
                               input int w, input int h, input logic [1:0] mode);
      logic [CSR_DATA_W-1:0] val [NUM_REGS];
      wait_drained();
      val[CSR_CORNER_A_X] = ax;
      val[CSR_CORNER_A_Y] = ay;
      val[CSR_CORNER_B_X] = bx;
      val[CSR_CORNER_B_Y] = by;
      val[CSR_IMAGE_WIDTH] = CSR_DATA_W'(w);
      val[CSR_IMAGE_HEIGHT] = CSR_DATA_W'(h);
      val[CSR_EXCHANGE_MODE] = CSR_DATA_W'(mode);
      pix_w = eff_extent(w);
      pix_h = eff_extent(h);
      // hold the write enable high across the whole burst
      for (int k = 0; k < NUM_REGS; k++) begin
         csr_write_en <= 1'b1;
         csr_index <= CSR_IDX_W'(k);
         csr_wdata <= val[k];
         @(posedge clock);
         sb.write_reg(CSR_IDX_W'(k), val[k]);
      end
      csr_write_en <= 1'b0;
      // let the derived geometry settle
      repeat (3) @(posedge clock);
      settings_done++;
   endtask

   task automatic random_settings();
      int w, h, ew, eh;
      logic [1:0] m;
      w = pick_dim();
      h = pick_dim();
      ew = eff_extent(w);
      eh = eff_extent(h);
      m = ($urandom_range(9) == 0) ? MODE_UNUSED : 2'($urandom_range(MODE_DIAG));
      set_geometry(pick_corner(ew), pick_corner(eh), pick_corner(ew), pick_corner(eh),
                   w, h, m);
   endtask

   initial begin
      logic [1:0]         dir_modes [4];
      logic [COORD_W-1:0] col, row;
      int                 cmax, rmax;
      sb = new();
      dir_modes = '{MODE_CW, MODE_CCW, MODE_DIAG, MODE_UNUSED};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // 9x7 image, odd leftover column and row; one pixel per quadrant and one outside
      for (int k = 0; k < 4; k++) begin
         set_geometry(16'd1, 16'd0, 16'd7, 16'd6, 9, 7, dir_modes[k]);
         drive_pixel(12'd2, 12'd5);
         drive_pixel(12'd5, 12'd5);
         drive_pixel(12'd2, 12'd2);
         drive_pixel(12'd5, 12'd2);
         drive_pixel(12'd7, 12'd0);
      end
      // zero and oversized dimensions, corners at the signed limits
      set_geometry(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0, DIM_REG_MAX, MODE_DIAG);
      drive_pixel(12'd4095, 12'd4095);
      drive_pixel(12'd0, 12'd0);
      drive_pixel(12'd0, 12'd4095);
      // full-size image, corners at the frame edges; columns 4094, 4095 and stored rows 0, 1 stay outside
      set_geometry(16'd0, 16'd0, 16'd4095, 16'd4095, MAX_DIM, MAX_DIM, MODE_CCW);
      drive_pixel(12'd0, 12'd0);
      drive_pixel(12'd4095, 12'd4095);
      drive_pixel(12'd2047, 12'd2048);
      drive_pixel(12'd2048, 12'd2047);

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         random_settings();
         case (ph % 4)
            0: begin
               tx_idle_pct = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct = 58;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct = 0;
               rx_stall_pct = 58;
            end
            default: begin
               tx_idle_pct = 9;
               rx_stall_pct = 9;
            end
         endcase
         // back up the pipe while requests keep coming
         if (ph % 4 == 2) begin
            hold_requests++;
         end
         cmax = (pix_w + 1 > COORD_MAX) ? COORD_MAX : pix_w + 1;
         rmax = (pix_h + 1 > COORD_MAX) ? COORD_MAX : pix_h + 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2 && ph % 2 == 1) begin
               wait_drained();
            end
            col = ($urandom_range(4) == 0) ? COORD_W'($urandom_range(COORD_MAX))
                                           : COORD_W'($urandom_range(cmax));
            row = ($urandom_range(4) == 0) ? COORD_W'($urandom_range(COORD_MAX))
                                           : COORD_W'($urandom_range(rmax));
            drive_pixel(col, row);
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("tb: %0d remapped coordinates checked over %0d register settings, all modes",
               sb.checked, settings_done);
      $display("tb: covered sender gaps, response stalls, %0d-cycle hold-offs, drained pauses",
               HOLD_CYCLES);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
